/* src/hotp_pkg.sv */
// ----------------------------------------------------------------------------
// hotp_pkg
// Shared constants, types and tables of the HOTP generator over HMAC-SHA256.
// ----------------------------------------------------------------------------
package hotp_pkg;

  localparam int KEY_BYTES   = 32;
  localparam int CODE_DIGITS = 6;

  localparam int KEY_W  = 256;
  localparam int CTR_W  = 64;
  localparam int CODE_W = 20;
  localparam int MOD_W  = 30;
  localparam int BIN_W  = 31;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 2;
  localparam int RND_W  = 6;

  // Block phases: inner pad, counter, outer pad, inner digest.
  localparam logic [1:0] PH_IPAD  = 2'd0;
  localparam logic [1:0] PH_CTR   = 2'd1;
  localparam logic [1:0] PH_OPAD  = 2'd2;
  localparam logic [1:0] PH_INNER = 2'd3;

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;

  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
  localparam logic [31:0] LEN_CTR    = 32'h0000_0240;
  localparam logic [31:0] LEN_INNER  = 32'h0000_0300;

  function automatic logic [MOD_W-1:0] pow10(input int n);
    logic [MOD_W-1:0] m;
    m = MOD_W'(1);
    for (int i = 0; i < n && i < 9; i++) m = MOD_W'(m * 10);
    return m;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(input int n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_W / 8; i++)
      if (i < n) m[KEY_W-1-8*i -: 8] = 8'hff;
    return m;
  endfunction

  localparam logic [MOD_W-1:0] MODULUS  = pow10(CODE_DIGITS);
  localparam logic [KEY_W-1:0] KEY_MASK = key_mask(KEY_BYTES);

  // The quotient of any 31-bit value by MODULUS is (value * RECIP) >> REM_SHIFT,
  // with RECIP rounded up so the result is exact over the whole input range.
  localparam int          REM_SHIFT = BIN_W + $clog2(MODULUS);
  localparam logic [63:0] RECIP_NUM = 64'd1 << REM_SHIFT;
  localparam logic [31:0] RECIP     =
    32'((RECIP_NUM + 64'(MODULUS) - 64'd1) / 64'(MODULUS));

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic             capture;
    logic             load_blk;
    logic             round;
    logic             add_h;
    logic             trunc;
    logic             quot_load;
    logic             rem_load;
    logic             out_load;
    logic [1:0]       phase;
    logic [RND_W-1:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

/* src/hotp_ctrl.sv */
// ----------------------------------------------------------------------------
// hotp_ctrl
// Sequencer: four compressions, truncation, remainder steps and result hand-off.
// ----------------------------------------------------------------------------
module hotp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hotp_pkg::status_t  status,
  output hotp_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_TRUNC = 3'd4;
  localparam logic [2:0] S_QUOT  = 3'd5;
  localparam logic [2:0] S_REM   = 3'd6;
  localparam logic [2:0] S_WAIT  = 3'd7;

  logic [2:0]                 state, state_next;
  logic [1:0]                 phase, phase_next;
  logic [hotp_pkg::RND_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= hotp_pkg::PH_IPAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.phase  = phase;
    cmd.rnd    = cnt;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          phase_next  = hotp_pkg::PH_IPAD;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_blk = 1'b1;
        cnt_next     = '0;
        state_next   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == '1) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add_h = 1'b1;
        if (phase == hotp_pkg::PH_INNER) begin
          state_next = S_TRUNC;
        end else begin
          phase_next = phase + 1'b1;
          state_next = S_LOAD;
        end
      end
      S_TRUNC: begin
        cmd.trunc  = 1'b1;
        state_next = S_QUOT;
      end
      S_QUOT: begin
        cmd.quot_load = 1'b1;
        state_next    = S_REM;
      end
      S_REM: begin
        cmd.rem_load = 1'b1;
        state_next   = S_WAIT;
      end
      S_WAIT: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/hotp_datapath.sv */
// ----------------------------------------------------------------------------
// hotp_datapath
// Key registers, SHA-256 round unit with rolling schedule, truncation,
// remainder by reciprocal multiplication and the output register.
// ----------------------------------------------------------------------------
module hotp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hotp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [hotp_pkg::CFG_W-1:0]    cfg_data,
  input  logic [hotp_pkg::CTR_W-1:0]    in_data,
  input  hotp_pkg::cmd_t                cmd,
  output hotp_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hotp_pkg::CODE_W-1:0]   out_code
);

  logic [63:0] key0, key1, key2, key3;
  logic [hotp_pkg::CTR_W-1:0] ctr;
  logic [31:0] hw [8];
  logic [31:0] v [8];
  logic [31:0] sched [16];
  logic [31:0] inner [8];
  logic [hotp_pkg::BIN_W-1:0] bin;
  logic [hotp_pkg::BIN_W-1:0] quot;
  logic [hotp_pkg::MOD_W-1:0] rem;

  logic [hotp_pkg::KEY_W-1:0] keym;
  logic [7:0]  pad;
  logic [31:0] blk [16];
  logic [31:0] w_new, s0, s1, t1, t2, e_sig, a_sig, ch, maj;
  logic [255:0] dig, dig_sh;
  logic [3:0]  off;
  logic [63:0] prod_q;
  logic [hotp_pkg::BIN_W-1:0] qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0;
      key1 <= '0;
      key2 <= '0;
      key3 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hotp_pkg::REG_KEY0: key0 <= cfg_data;
        hotp_pkg::REG_KEY1: key1 <= cfg_data;
        hotp_pkg::REG_KEY2: key2 <= cfg_data;
        hotp_pkg::REG_KEY3: key3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Message block of the current phase.
  always_comb begin
    keym = {key0, key1, key2, key3} & hotp_pkg::KEY_MASK;
    pad  = (cmd.phase == hotp_pkg::PH_OPAD) ? hotp_pkg::OPAD : hotp_pkg::IPAD;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    unique case (cmd.phase)
      hotp_pkg::PH_IPAD, hotp_pkg::PH_OPAD: begin
        for (int i = 0; i < 8; i++) blk[i] = keym[255-32*i -: 32] ^ {4{pad}};
        for (int i = 8; i < 16; i++) blk[i] = {4{pad}};
      end
      hotp_pkg::PH_CTR: begin
        blk[0]  = ctr[63:32];
        blk[1]  = ctr[31:0];
        blk[2]  = hotp_pkg::PAD_WORD;
        blk[15] = hotp_pkg::LEN_CTR;
      end
      default: begin
        for (int i = 0; i < 8; i++) blk[i] = inner[i];
        blk[8]  = hotp_pkg::PAD_WORD;
        blk[15] = hotp_pkg::LEN_INNER;
      end
    endcase
  end

  always_comb begin
    s0    = {sched[1][6:0], sched[1][31:7]} ^ {sched[1][17:0], sched[1][31:18]} ^
            (sched[1] >> 3);
    s1    = {sched[14][16:0], sched[14][31:17]} ^ {sched[14][18:0], sched[14][31:19]} ^
            (sched[14] >> 10);
    w_new = s1 + sched[9] + s0 + sched[0];
    e_sig = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    a_sig = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + e_sig + ch + hotp_pkg::ROUND_K[cmd.rnd] + sched[0];
    t2    = a_sig + maj;
  end

  // Dynamic truncation: four digest bytes starting at the byte offset given by the low nibble.
  always_comb begin
    dig    = {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
    off    = hw[7][3:0];
    dig_sh = dig << {off, 3'b000};
  end

  // The quotient comes from a multiply by the rounded-up reciprocal; the
  // remainder is then the value minus quotient times modulus.
  always_comb begin
    prod_q = 64'(bin) * 64'(hotp_pkg::RECIP);
    qd     = hotp_pkg::BIN_W'(quot * {1'b0, hotp_pkg::MODULUS});
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ctr <= in_data;
      for (int i = 0; i < 8; i++) hw[i] <= hotp_pkg::INIT_H[i];
    end
    if (cmd.load_blk) begin
      for (int i = 0; i < 16; i++) sched[i] <= blk[i];
      for (int i = 0; i < 8; i++) v[i] <= hw[i];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
      sched[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (cmd.add_h) begin
      if (cmd.phase == hotp_pkg::PH_CTR) begin
        for (int i = 0; i < 8; i++) begin
          inner[i] <= hw[i] + v[i];
          hw[i]    <= hotp_pkg::INIT_H[i];
        end
      end else begin
        for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
      end
    end
    if (cmd.trunc) bin <= dig_sh[254 -: hotp_pkg::BIN_W];
    if (cmd.quot_load) quot <= hotp_pkg::BIN_W'(prod_q >> hotp_pkg::REM_SHIFT);
    if (cmd.rem_load) rem <= hotp_pkg::MOD_W'(bin - qd);
    if (cmd.out_load) out_code <= rem[hotp_pkg::CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  assign status.out_full = out_valid;

endmodule

/* src/hotp_sha256_generator_core.sv */
// ----------------------------------------------------------------------------
// hotp_sha256_generator_core
// HOTP code generator: HMAC-SHA256 over a 64-bit counter, dynamic truncation
// and reduction modulo ten to the digit count.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata[63:0] counter_value
// m_axis    out        tdata[19:0] otp_code, [23:20] zero
// cfg       in         key_word_0..3 by index 0..3
//
// A request passes through the accepting state, four compressions (load, 64
// rounds through the single round unit, hash update), truncation, the
// quotient and remainder steps, and the result hand-off.
// Reset is synchronous and clears the keys and the sequencer. A held result
// waits in the output register; a new request is taken meanwhile and only
// its own hand-off waits for that register to drain.
// ----------------------------------------------------------------------------
module hotp_sha256_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] counter_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] otp_code, [23:20] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  hotp_pkg::cmd_t    cmd;
  hotp_pkg::status_t status;
  logic [hotp_pkg::CODE_W-1:0] code;

  hotp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hotp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_code  (code)
  );

  assign m_axis_tdata = {4'b0000, code};

endmodule
